[design/bta_pkg.sv]
package bta_pkg;

  // block states kept in each header
  localparam logic [1:0] BLK_FREE  = 2'd0;
  localparam logic [1:0] BLK_ALLOC = 2'd1;
  localparam logic [1:0] BLK_FIRST = 2'd2;
  localparam logic [1:0] BLK_LAST  = 2'd3;

  // result status codes
  localparam logic [1:0] RES_DONE    = 2'd0;
  localparam logic [1:0] RES_OOM     = 2'd1;
  localparam logic [1:0] RES_IGNORED = 2'd2;

  // request commands
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // configuration register indexes
  localparam logic [2:0] CFG_HEAP_LIMIT = 3'd0;
  localparam logic [2:0] CFG_BEST_FIT   = 3'd1;
  localparam logic [2:0] CFG_SPLIT      = 3'd2;
  localparam logic [2:0] CFG_MERGE      = 3'd3;

  localparam int HEADER_BYTES = 12;
  localparam int MIN_SPLIT    = HEADER_BYTES + 4;

  typedef enum logic [3:0] {
    S_INIT0, S_INIT1, S_IDLE,
    S_A_RD, S_A_CHK, S_A_DEC, S_A_S2, S_A_S3, S_A_AP,
    S_F_RD, S_F_CHK, S_F_P, S_F_N, S_F_W1, S_F_W2
  } st_t;

endpackage

[design/bta_ram.sv]
module bta_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/boundary_tag_heap_allocator_top.sv]
// Boundary-tag heap allocator, first fit or best fit.
// Requests: raise start with command, request_size and block_address; the
// request is taken at a clock edge where start is high and busy is low.
// Results: done is high for exactly one cycle with status, data_address and
// block_size; the receiver cannot stall, so the result is simply presented.
// Configuration: cfg_we/cfg_index/cfg_data write one register per cycle; the
// user must write only while busy is low and no result is pending. The block
// does not enforce this. Allocate: the walk reads one block header per cycle
// up to the last marker, or to the first fit in first-fit mode; a found
// block's header is then written, plus the split headers for a split, while
// a heap extension writes the old last header and a new last marker. A free
// reads its header, and with merging the previous and next headers, before
// writing back. An ignored free of a bad address answers straight from idle.
// One request is in flight at a time. Reset: rst resets control registers
// and loads defaults; then the first and last markers are written, busy high.
module boundary_tag_heap_allocator_top #(
  parameter int HEAP_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        command,
  input  logic [16:0] request_size,
  input  logic [16:0] block_address,
  output logic        done,
  output logic [1:0]  status,
  output logic [16:0] data_address,
  output logic [16:0] block_size,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data
);
  import bta_pkg::*;

  localparam int DEPTH = HEAP_BYTES / 4;
  localparam int AW    = $clog2(DEPTH);
  localparam int OW    = $clog2(HEAP_BYTES) + 1;
  localparam int SW    = ((OW > 17) ? OW : 17) + 2;
  localparam int HW    = 2 * OW + 2;
  localparam logic [SW-1:0] HB   = SW'(HEAP_BYTES);
  localparam logic [SW-1:0] HDRB = SW'(HEADER_BYTES);

  function automatic logic [HW-1:0] mk(input logic [SW-1:0] sz,
                                       input logic [SW-1:0] pv,
                                       input logic [1:0] s);
    mk = {sz[OW-1:0], pv[OW-1:0], s};
  endfunction

  function automatic logic [SW-1:0] hsz(input logic [HW-1:0] h);
    hsz = SW'(h[HW-1 -: OW]);
  endfunction

  function automatic logic [SW-1:0] hpv(input logic [HW-1:0] h);
    hpv = SW'(h[2 +: OW]);
  endfunction

  function automatic logic [AW-1:0] ix(input logic [SW-1:0] o);
    ix = o[AW+1:2];
  endfunction

  st_t state, state_next;

  // configuration
  logic [16:0] heap_limit;
  logic        best_fit, split_enable, merge_enable;

  // request context
  logic [SW-1:0] need, off, best, found_off, olast, last_off, hoff;
  logic          have;
  logic [HW-1:0] found_hdr, olast_hdr, node_hdr, prev_hdr, next_hdr, tmp_hdr;

  // RAM ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [HW-1:0] ram_wdata, rdata;

  // result to register
  logic          fire;
  logic [1:0]    r_status;
  logic [SW-1:0] r_addr, r_size;

  bta_ram #(.WIDTH(HW), .DEPTH(DEPTH)) u_hdr (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(rdata)
  );

  // derived values
  logic [SW-1:0] rd_sz, sur, rest, nlast, noff, total, nsz;
  logic          fit, take, do_split, oom, bad_addr, prevfree, nextfree;

  always_comb begin
    rd_sz    = hsz(rdata);
    sur      = rd_sz - need;
    fit      = (rdata[1:0] == BLK_FREE) && (rd_sz >= need);
    take     = fit && (sur < best);
    rest     = hsz(found_hdr) - need;
    do_split = split_enable && (rest >= SW'(MIN_SPLIT));
    nlast    = olast + need;
    oom      = (nlast >= SW'(heap_limit)) || (nlast >= HB);
    bad_addr = (block_address == 17'd0) || (block_address[1:0] != 2'b00) ||
               (block_address < 17'(HEADER_BYTES));
    nsz      = hsz(node_hdr);
    noff     = hoff + nsz;
    prevfree = (prev_hdr[1:0] == BLK_FREE);
    nextfree = (next_hdr[1:0] == BLK_FREE);
    total    = (prevfree ? hsz(prev_hdr) + nsz : nsz) +
               (nextfree ? hsz(next_hdr) : '0);
  end

  assign busy = (state != S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT0: state_next = S_INIT1;
      S_INIT1: state_next = S_IDLE;
      S_IDLE: begin
        if (start) begin
          if (command == CMD_ALLOC) state_next = S_A_RD;
          else if (!bad_addr)       state_next = S_F_RD;
        end
      end
      S_A_RD: state_next = S_A_CHK;
      S_A_CHK: begin
        if (rdata[1:0] == BLK_LAST)  state_next = S_A_DEC;
        else if (take && !best_fit)  state_next = S_A_DEC;
        else if (rd_sz == '0)        state_next = S_A_DEC;
      end
      S_A_DEC: begin
        if (have)      state_next = do_split ? S_A_S2 : S_IDLE;
        else if (oom)  state_next = S_IDLE;
        else           state_next = S_A_AP;
      end
      S_A_S2: state_next = S_A_S3;
      S_A_S3: state_next = S_IDLE;
      S_A_AP: state_next = S_IDLE;
      S_F_RD: state_next = S_F_CHK;
      S_F_CHK: begin
        if (rdata[1:0] != BLK_ALLOC) state_next = S_IDLE;
        else if (merge_enable)       state_next = S_F_P;
        else                         state_next = S_IDLE;
      end
      S_F_P:  state_next = S_F_N;
      S_F_N:  state_next = S_F_W1;
      S_F_W1: state_next = nextfree ? S_F_W2 : S_IDLE;
      S_F_W2: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // memory control and result
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    fire      = 1'b0;
    r_status  = RES_DONE;
    r_addr    = '0;
    r_size    = '0;
    unique case (state)
      S_INIT0: begin
        ram_we = 1'b1; ram_waddr = ix('0); ram_wdata = mk(HDRB, '0, BLK_FIRST);
      end
      S_INIT1: begin
        ram_we = 1'b1; ram_waddr = ix(HDRB); ram_wdata = mk(HDRB, HDRB, BLK_LAST);
      end
      S_IDLE: begin
        if (start && command == CMD_FREE && bad_addr) begin
          fire = 1'b1; r_status = RES_IGNORED;
        end
      end
      S_A_RD: ram_raddr = ix(off);
      S_A_CHK: ram_raddr = ix(off + rd_sz);
      S_A_DEC: begin
        if (have) begin
          ram_we    = 1'b1;
          ram_waddr = ix(found_off);
          ram_wdata = do_split ? mk(need, hpv(found_hdr), BLK_ALLOC)
                               : mk(hsz(found_hdr), hpv(found_hdr), BLK_ALLOC);
          ram_raddr = ix(found_off + hsz(found_hdr));
          if (!do_split) begin
            fire = 1'b1; r_addr = found_off + HDRB; r_size = hsz(found_hdr);
          end
        end else if (oom) begin
          fire = 1'b1; r_status = RES_OOM;
        end else begin
          ram_we = 1'b1; ram_waddr = ix(olast);
          ram_wdata = mk(need, hpv(olast_hdr), BLK_ALLOC);
        end
      end
      S_A_S2: begin
        ram_we = 1'b1; ram_waddr = ix(found_off + need);
        ram_wdata = mk(rest, need, BLK_FREE);
      end
      S_A_S3: begin
        ram_we = 1'b1; ram_waddr = ix(found_off + hsz(found_hdr));
        ram_wdata = mk(hsz(tmp_hdr), rest, tmp_hdr[1:0]);
        fire = 1'b1; r_addr = found_off + HDRB; r_size = need;
      end
      S_A_AP: begin
        ram_we = 1'b1; ram_waddr = ix(nlast); ram_wdata = mk(HDRB, need, BLK_LAST);
        fire = 1'b1; r_addr = olast + HDRB; r_size = need;
      end
      S_F_RD: ram_raddr = ix(hoff);
      S_F_CHK: begin
        if (rdata[1:0] != BLK_ALLOC) begin
          fire = 1'b1; r_status = RES_IGNORED;
        end else begin
          ram_we = 1'b1; ram_waddr = ix(hoff);
          ram_wdata = mk(rd_sz, hpv(rdata), BLK_FREE);
          ram_raddr = ix(hoff - hpv(rdata));
          if (!merge_enable) begin
            fire = 1'b1; r_size = rd_sz;
          end
        end
      end
      S_F_P: ram_raddr = ix(noff);
      S_F_N: begin
        // previous block free: its grown size goes into the next header
        ram_we    = prevfree;
        ram_waddr = ix(noff);
        ram_wdata = mk(hsz(rdata), hsz(prev_hdr) + nsz, rdata[1:0]);
        ram_raddr = ix(noff + hsz(rdata));
      end
      S_F_W1: begin
        ram_we    = 1'b1;
        ram_waddr = prevfree ? ix(hoff - hpv(node_hdr)) : ix(hoff);
        ram_wdata = prevfree ? mk(total, hpv(prev_hdr), prev_hdr[1:0])
                             : mk(total, hpv(node_hdr), BLK_FREE);
        if (!nextfree) begin
          fire = 1'b1; r_size = nsz;
        end
      end
      S_F_W2: begin
        ram_we = 1'b1; ram_waddr = ix(noff + hsz(next_hdr));
        ram_wdata = mk(hsz(tmp_hdr), total, tmp_hdr[1:0]);
        fire = 1'b1; r_size = nsz;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT0;
      done         <= 1'b0;
      last_off     <= HDRB;
      heap_limit   <= 17'h10000;
      best_fit     <= 1'b0;
      split_enable <= 1'b1;
      merge_enable <= 1'b1;
    end else begin
      state <= state_next;
      done  <= fire;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_HEAP_LIMIT: heap_limit   <= cfg_data;
          CFG_BEST_FIT:   best_fit     <= cfg_data[0];
          CFG_SPLIT:      split_enable <= cfg_data[0];
          CFG_MERGE:      merge_enable <= cfg_data[0];
          default: ;
        endcase
      end
      if (state == S_A_AP) last_off <= nlast;
    end
  end

  // request datapath
  always_ff @(posedge clk) begin
    if (fire) begin
      status       <= r_status;
      data_address <= r_addr[16:0];
      block_size   <= r_size[16:0];
    end
    unique case (state)
      S_IDLE: begin
        need  <= ((SW'(request_size) + SW'(3)) & ~SW'(3)) + HDRB;
        off   <= '0;
        best  <= '1;
        have  <= 1'b0;
        olast <= last_off;
        hoff  <= SW'(block_address) - HDRB;
      end
      S_A_CHK: begin
        if (rdata[1:0] == BLK_LAST) begin
          olast     <= off;
          olast_hdr <= rdata;
        end
        if (take) begin
          best      <= sur;
          found_off <= off;
          found_hdr <= rdata;
          have      <= 1'b1;
        end
        off <= off + rd_sz;
      end
      S_A_S2:  tmp_hdr  <= rdata;
      S_F_CHK: node_hdr <= rdata;
      S_F_P:   prev_hdr <= rdata;
      S_F_N:   next_hdr <= rdata;
      S_F_W1:  tmp_hdr  <= rdata;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_done_from_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) != S_IDLE || $past(start))
    else $error("result without a request");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result while still busy");
  a_oom_empty: assert property (@(posedge clk) disable iff (rst)
    (done && status == RES_OOM) |-> (data_address == 17'd0 && block_size == 17'd0))
    else $error("out of memory result carries data");
  a_last_aligned: assert property (@(posedge clk) disable iff (rst)
    last_off[1:0] == 2'b00 && last_off >= HDRB)
    else $error("last marker misplaced");
`endif

endmodule

[bench/tb_boundary_tag_heap_allocator_top.sv]
`timescale 1ns / 1ps

module tb_boundary_tag_heap_allocator_top;
  import bta_pkg::*;

  localparam int STORE_DEPTH = 16384;

  typedef struct {
    logic        command;
    logic [16:0] request_size;
    logic [16:0] block_address;
  } heap_req_t;

  typedef struct {
    logic [1:0]  status;
    logic [16:0] data_address;
    logic [16:0] block_size;
  } heap_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        command = CMD_ALLOC;
  logic [16:0] request_size = '0;
  logic [16:0] block_address = '0;
  logic        done;
  logic [1:0]  status;
  logic [16:0] data_address;
  logic [16:0] block_size;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = CFG_HEAP_LIMIT;
  logic [16:0] cfg_data = '0;

  boundary_tag_heap_allocator_top DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .request_size(request_size), .block_address(block_address), .done(done),
    .status(status), .data_address(data_address), .block_size(block_size),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow heap: one header per 4-byte word
  int unsigned hdr_size [STORE_DEPTH];
  int unsigned hdr_prev [STORE_DEPTH];
  bit [1:0]    hdr_state [STORE_DEPTH];
  bit          hdr_touched [STORE_DEPTH];
  int unsigned last_off;
  int unsigned lim_bytes = 65536;
  bit          pick_tightest = 1'b0;
  bit          do_split = 1'b1;
  bit          do_merge = 1'b1;

  // offsets whose state was ever written, and granted data offsets
  int unsigned touched_offs[$];
  int unsigned granted[$];

  heap_req_t pending_reqs[$];
  heap_res_t awaited_results[$];
  int issued = 0;
  int taken = 0;
  int sender_idle_pct = 0;
  int errors = 0;
  int n_granted = 0, n_oom = 0, n_freed = 0, n_ignored = 0, n_split = 0;

  function automatic int unsigned slot(int unsigned off);
    return off[15:2];
  endfunction

  function automatic void set_state(int unsigned off, bit [1:0] st);
    int unsigned i;
    i = slot(off);
    hdr_state[i] = st;
    if (!hdr_touched[i]) begin
      hdr_touched[i] = 1'b1;
      touched_offs.push_back(off);
    end
  endfunction

  // work out the result of one allocate
  function automatic heap_res_t alloc_block(int unsigned req);
    int unsigned need, off, found, best, olast, surplus, rest, after, nlast, n, i;
    bit have;
    heap_res_t r;
    need = (((req + 3) >> 2) << 2) + HEADER_BYTES;
    off = 0; found = 0; have = 0; best = 32'hFFFF_FFFF; olast = last_off;
    for (int steps = 0; steps <= STORE_DEPTH; steps++) begin
      i = slot(off);
      if (hdr_state[i] == BLK_LAST) begin
        olast = off;
        break;
      end
      if (hdr_state[i] == BLK_FREE && hdr_size[i] >= need) begin
        surplus = hdr_size[i] - need;
        if (surplus < best) begin
          best = surplus;
          found = off;
          have = 1'b1;
          if (!pick_tightest) break;
        end
      end
      if (hdr_size[i] == 0) break;
      off += hdr_size[i];
    end
    if (have) begin
      n = slot(found);
      rest = hdr_size[n] - need;
      if (do_split && rest >= MIN_SPLIT) begin
        after = found + hdr_size[n];
        hdr_size[n] = need;
        set_state(found + need, BLK_FREE);
        hdr_size[slot(found + need)] = rest;
        hdr_prev[slot(found + need)] = need;
        hdr_prev[slot(after)] = rest;
        n_split++;
      end
      set_state(found, BLK_ALLOC);
      r.status = RES_DONE;
      r.data_address = 17'(found + HEADER_BYTES);
      r.block_size = 17'(hdr_size[n]);
      return r;
    end
    nlast = olast + need;
    if (nlast >= lim_bytes || (nlast >> 2) >= STORE_DEPTH) begin
      r.status = RES_OOM;
      r.data_address = '0;
      r.block_size = '0;
      return r;
    end
    set_state(olast, BLK_ALLOC);
    hdr_size[slot(olast)] = need;
    set_state(nlast, BLK_LAST);
    hdr_size[slot(nlast)] = HEADER_BYTES;
    hdr_prev[slot(nlast)] = need;
    last_off = nlast;
    r.status = RES_DONE;
    r.data_address = 17'(olast + HEADER_BYTES);
    r.block_size = 17'(need);
    return r;
  endfunction

  // work out the result of one free, merging if enabled
  function automatic heap_res_t free_block(int unsigned addr);
    int unsigned hoff, node, noff, pv, nx, cur, nx2;
    heap_res_t r;
    r.data_address = '0;
    r.status = RES_IGNORED;
    r.block_size = '0;
    if (addr == 0 || addr[1:0] != 0 || addr < HEADER_BYTES) return r;
    hoff = addr - HEADER_BYTES;
    node = slot(hoff);
    if (hdr_state[node] != BLK_ALLOC) return r;
    set_state(hoff, BLK_FREE);
    r.status = RES_DONE;
    r.block_size = 17'(hdr_size[node]);
    if (do_merge) begin
      noff = hoff + hdr_size[node];
      pv = slot(hoff - hdr_prev[node]);
      nx = slot(noff);
      cur = node;
      if (hdr_state[pv] == BLK_FREE) begin
        hdr_size[pv] += hdr_size[node];
        hdr_prev[nx] = hdr_size[pv];
        cur = pv;
      end
      if (hdr_state[nx] == BLK_FREE) begin
        nx2 = slot(noff + hdr_size[nx]);
        hdr_size[cur] += hdr_size[nx];
        hdr_prev[nx2] = hdr_size[cur];
      end
    end
    return r;
  endfunction

  task automatic predict_request(heap_req_t q);
    heap_res_t r;
    if (q.command == CMD_ALLOC) begin
      r = alloc_block(q.request_size);
      if (r.status == RES_DONE) begin
        granted.push_back(r.data_address);
        n_granted++;
      end else begin
        n_oom++;
      end
    end else begin
      r = free_block(q.block_address);
      if (r.status == RES_DONE) n_freed++;
      else n_ignored++;
    end
    awaited_results.push_back(r);
  endtask

  // request driver
  always @(posedge clk) begin : drive_requests
    heap_req_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        nxt.command = command;
        nxt.request_size = request_size;
        nxt.block_address = block_address;
        predict_request(nxt);
        taken++;
      end
      if (!start || !busy) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          nxt = pending_reqs.pop_front();
          start <= 1'b1;
          command <= nxt.command;
          request_size <= nxt.request_size;
          block_address <= nxt.block_address;
          issued++;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : check_results
    heap_res_t e;
    if (!rst && done) begin
      if (awaited_results.size() == 0) begin
        $error("result with nothing outstanding: status %0d addr %0d size %0d",
               status, data_address, block_size);
        errors++;
      end else begin
        e = awaited_results.pop_front();
        if (status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, status);
          errors++;
        end
        if (data_address !== e.data_address) begin
          $error("data_address: expected %0d, got %0d", e.data_address, data_address);
          errors++;
        end
        if (block_size !== e.block_size) begin
          $error("block_size: expected %0d, got %0d", e.block_size, block_size);
          errors++;
        end
      end
    end
  end

  // wait until the previous request has been taken and predicted
  task automatic wait_ready();
    do @(negedge clk); while (pending_reqs.size() != 0 || issued != taken);
  endtask

  task automatic issue(logic cmd, logic [16:0] req, logic [16:0] addr);
    heap_req_t q;
    wait_ready();
    q.command = cmd;
    q.request_size = req;
    q.block_address = addr;
    pending_reqs.push_back(q);
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || issued != taken || awaited_results.size() != 0 || busy);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [16:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
  endtask

  task automatic configure(int unsigned lim, bit bf, bit sp, bit mg);
    write_reg(CFG_HEAP_LIMIT, 17'(lim));
    write_reg(CFG_BEST_FIT, 17'(bf));
    write_reg(CFG_SPLIT, 17'(sp));
    write_reg(CFG_MERGE, 17'(mg));
    @(posedge clk);
    cfg_we <= 1'b0;
    lim_bytes = lim;
    pick_tightest = bf;
    do_split = sp;
    do_merge = mg;
  endtask

  // pick a free target: mostly a granted block, else a known header or a bad address
  function automatic logic [16:0] free_target();
    int unsigned p, a;
    p = $urandom_range(99);
    if (p < 60 && granted.size() != 0)
      return 17'(granted[$urandom_range(granted.size() - 1)]);
    if (p < 82) begin
      a = touched_offs[$urandom_range(touched_offs.size() - 1)] + HEADER_BYTES;
      if (a <= 65536) return 17'(a);
      if (granted.size() != 0) return 17'(granted[$urandom_range(granted.size() - 1)]);
      return 17'd0;
    end
    case ($urandom_range(3))
      0: return 17'd0;
      1: return 17'($urandom_range(2)) << 2;
      default: begin
        a = $urandom_range(65536);
        if (a[1:0] == 0) a = (a == 65536) ? 65535 : a | $urandom_range(1, 3);
        return 17'(a);
      end
    endcase
  endfunction

  function automatic logic [16:0] alloc_size();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 70) return 17'($urandom_range(64));
    if (p < 92) return 17'($urandom_range(65, 600));
    return 17'($urandom_range(65536));
  endfunction

  int unsigned ph_limit [6] = '{16384, 4096, 65536, 2048, 0, 8192};
  bit          ph_best  [6] = '{0, 1, 1, 0, 0, 1};
  bit          ph_split [6] = '{1, 1, 0, 0, 1, 1};
  bit          ph_merge [6] = '{1, 0, 1, 1, 0, 1};
  int          ph_idle  [6] = '{0, 67, 22, 67, 0, 22};
  int          ph_count [6] = '{110, 110, 100, 100, 30, 100};

  initial begin : stimulus
    logic [16:0] a, b, c;
    // heap after reset: first marker at 0, last marker at 12
    set_state(0, BLK_FIRST);
    hdr_size[0] = HEADER_BYTES;
    set_state(HEADER_BYTES, BLK_LAST);
    hdr_size[slot(HEADER_BYTES)] = HEADER_BYTES;
    hdr_prev[slot(HEADER_BYTES)] = HEADER_BYTES;
    last_off = HEADER_BYTES;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: fill the heap to the top, probe the last marker, then reuse
    issue(CMD_ALLOC, 17'd65500, 17'd0);
    issue(CMD_FREE, 17'd0, 17'd65536);
    issue(CMD_ALLOC, 17'd65536, 17'd0);
    issue(CMD_FREE, 17'd0, 17'd24);
    issue(CMD_ALLOC, 17'd0, 17'd0);
    issue(CMD_ALLOC, 17'd1, 17'd0);
    // null, unaligned, too small, first marker
    issue(CMD_FREE, 17'd0, 17'd0);
    issue(CMD_FREE, 17'd0, 17'd6);
    issue(CMD_FREE, 17'd0, 17'd8);
    issue(CMD_FREE, 17'd0, 17'd12);
    // split, then free of the same block twice, then merge both ways
    issue(CMD_ALLOC, 17'd100, 17'd0);
    wait_ready(); a = 17'(granted[$]);
    issue(CMD_ALLOC, 17'd4, 17'd0);
    wait_ready(); b = 17'(granted[$]);
    issue(CMD_ALLOC, 17'd8, 17'd0);
    wait_ready(); c = 17'(granted[$]);
    issue(CMD_FREE, 17'd0, a);
    issue(CMD_FREE, 17'd0, a);
    issue(CMD_ALLOC, 17'd20, 17'd0);
    issue(CMD_FREE, 17'd0, c);
    issue(CMD_FREE, 17'd0, b);
    issue(CMD_FREE, 17'd0, 17'd24);
    issue(CMD_ALLOC, 17'd131071 & 17'h1FFFF, 17'd0);
    drain();

    // random phases across settings
    for (int ph = 0; ph < 6; ph++) begin
      configure(ph_limit[ph], ph_best[ph], ph_split[ph], ph_merge[ph]);
      sender_idle_pct = ph_idle[ph];
      for (int k = 0; k < ph_count[ph]; k++) begin
        if (ph == 1 && k == ph_count[ph] / 2) drain();
        if ($urandom_range(99) < 55) issue(CMD_ALLOC, alloc_size(), 17'($urandom_range(65536)));
        else issue(CMD_FREE, 17'($urandom_range(65536)), free_target());
      end
      drain();
    end
    configure(65536, 0, 1, 1);
    sender_idle_pct = 0;

    $display("requests: %0d granted, %0d out of memory, %0d freed, %0d ignored frees",
             n_granted, n_oom, n_freed, n_ignored);
    $display("splits seen: %0d; six settings incl. limit 0 and 65536, both fit modes",
             n_split);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #60_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

[boundary_tag_heap_allocator_top.f]
design/bta_pkg.sv
design/bta_ram.sv
design/boundary_tag_heap_allocator_top.sv
bench/tb_boundary_tag_heap_allocator_top.sv
